// ===== rtl/mh2_pkg.sv =====
// shared types and constants of the byte-stream murmurhash2 block
package mh2_pkg;

    // mixing multiplier of murmurhash2
    localparam logic [31:0] MIX_MUL = 32'h5bd1e995;

    // shift amounts of the word mix and of the final avalanche
    localparam int MIX_SHIFT   = 24;
    localparam int FIN_SHIFT_A = 13;
    localparam int FIN_SHIFT_B = 15;

    // command handed from the front to the back through the queue
    typedef struct packed {
        logic        seed;      // first byte of a key: load seed_len into the hash
        logic [15:0] seed_len;  // saturated key length
        logic        mix;       // word holds a full four-byte block
        logic        tail;      // word holds one to three leftover bytes
        logic        fin;       // apply avalanche and emit
        logic [31:0] word;
    } cmd_t;

    localparam int CMD_W = $bits(cmd_t);

    // back sequencer states
    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_MIX_A = 7'b0000010,
        ST_MIX_B = 7'b0000100,
        ST_MIX_C = 7'b0001000,
        ST_TAIL  = 7'b0010000,
        ST_FIN   = 7'b0100000,
        ST_OUT   = 7'b1000000
    } back_state_t;

endpackage

// ===== rtl/mh2_front.sv =====
// front: accepts key bytes, packs words and issues hash commands
module mh2_front #(
    parameter logic [31:0] MAX_KEY_BYTES = 32'd65535
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_data_byte,
    input  logic [15:0]        s_key_length,
    input  logic               s_last_byte,
    input  logic               q_full,
    output logic               q_push,
    output mh2_pkg::cmd_t      q_cmd
);

    logic        inside_reg, inside_next;
    logic [1:0]  phase_reg, phase_next;
    logic [23:0] pw_reg, pw_next;

    logic        accept;
    logic        first;
    logic [15:0] sat_len;
    logic [1:0]  cur_phase;
    logic [23:0] cur_pw;
    logic [23:0] upd_pw;
    logic [1:0]  upd_phase;
    logic        full_word;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign first   = !inside_reg;

    // length saturation to the configured bound
    always_comb begin
        if ({16'd0, s_key_length} > MAX_KEY_BYTES) begin
            sat_len = MAX_KEY_BYTES[15:0];
        end else begin
            sat_len = s_key_length;
        end
    end

    // byte packing, little-endian
    always_comb begin
        cur_phase = first ? 2'd0 : phase_reg;
        cur_pw    = first ? 24'd0 : pw_reg;
        full_word = (cur_phase == 2'd3);
        upd_pw    = cur_pw;
        case (cur_phase)
            2'd0:    upd_pw[7:0]   = s_data_byte;
            2'd1:    upd_pw[15:8]  = s_data_byte;
            2'd2:    upd_pw[23:16] = s_data_byte;
            default: upd_pw        = 24'd0;
        endcase
        upd_phase = cur_phase + 2'd1;
    end

    // command build and front state update
    always_comb begin
        inside_next = inside_reg;
        phase_next  = phase_reg;
        pw_next     = pw_reg;
        q_cmd          = '0;
        q_cmd.seed     = first;
        q_cmd.seed_len = sat_len;
        q_push         = 1'b0;
        if (accept) begin
            if (first && sat_len == 16'd0) begin
                // empty key: seed of zero straight into the avalanche
                q_cmd.fin = 1'b1;
                q_push    = 1'b1;
            end else begin
                q_cmd.mix  = full_word;
                q_cmd.word = full_word ? {s_data_byte, cur_pw} : {8'd0, upd_pw};
                if (s_last_byte) begin
                    q_cmd.tail  = !full_word;
                    q_cmd.fin   = 1'b1;
                    inside_next = 1'b0;
                    phase_next  = 2'd0;
                    pw_next     = 24'd0;
                end else begin
                    inside_next = 1'b1;
                    phase_next  = upd_phase;
                    pw_next     = full_word ? 24'd0 : upd_pw;
                end
                q_push = first || full_word || s_last_byte;
            end
        end
    end

    // front state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inside_reg <= 1'b0;
            phase_reg  <= 2'd0;
            pw_reg     <= 24'd0;
        end else begin
            inside_reg <= inside_next;
            phase_reg  <= phase_next;
            pw_reg     <= pw_next;
        end
    end

endmodule

// ===== rtl/mh2_fifo.sv =====
// short command queue between front and back
module mh2_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/mh2_back.sv =====
// back: sequencer over one shared multiplier, holds the result register
module mh2_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_empty,
    input  mh2_pkg::cmd_t      q_cmd,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [31:0]        m_hash_value
);

    mh2_pkg::back_state_t state_reg, state_next;
    mh2_pkg::cmd_t        cmd_reg;
    logic [31:0]          h_reg, h_next;
    logic [31:0]          k_reg, k_next;
    logic                 out_valid_reg, out_valid_next;
    logic [31:0]          out_reg, out_next;
    logic [31:0]          mul_a;
    logic [31:0]          mul_p;
    logic                 out_free;

    assign out_free = !out_valid_reg || m_ready;
    assign q_pop    = (state_reg == mh2_pkg::ST_IDLE) && !q_empty;

    // shared multiplier operand select
    always_comb begin
        case (state_reg)
            mh2_pkg::ST_MIX_A: mul_a = cmd_reg.word;
            mh2_pkg::ST_MIX_B: mul_a = k_reg ^ (k_reg >> mh2_pkg::MIX_SHIFT);
            mh2_pkg::ST_MIX_C: mul_a = h_reg;
            mh2_pkg::ST_TAIL:  mul_a = h_reg ^ cmd_reg.word;
            mh2_pkg::ST_FIN:   mul_a = h_reg ^ (h_reg >> mh2_pkg::FIN_SHIFT_A);
            default:           mul_a = h_reg;
        endcase
        mul_p = mul_a * mh2_pkg::MIX_MUL;
    end

    // sequencer
    always_comb begin
        state_next     = state_reg;
        h_next         = h_reg;
        k_next         = k_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            mh2_pkg::ST_IDLE: begin
                if (!q_empty) begin
                    if (q_cmd.seed) begin
                        h_next = {16'd0, q_cmd.seed_len};
                    end
                    if (q_cmd.mix) begin
                        state_next = mh2_pkg::ST_MIX_A;
                    end else if (q_cmd.tail) begin
                        state_next = mh2_pkg::ST_TAIL;
                    end else if (q_cmd.fin) begin
                        state_next = mh2_pkg::ST_FIN;
                    end
                end
            end
            mh2_pkg::ST_MIX_A: begin
                k_next     = mul_p;
                state_next = mh2_pkg::ST_MIX_B;
            end
            mh2_pkg::ST_MIX_B: begin
                k_next     = mul_p;
                state_next = mh2_pkg::ST_MIX_C;
            end
            mh2_pkg::ST_MIX_C: begin
                h_next     = mul_p ^ k_reg;
                state_next = cmd_reg.fin ? mh2_pkg::ST_FIN : mh2_pkg::ST_IDLE;
            end
            mh2_pkg::ST_TAIL: begin
                h_next     = mul_p;
                state_next = mh2_pkg::ST_FIN;
            end
            mh2_pkg::ST_FIN: begin
                h_next     = mul_p;
                state_next = mh2_pkg::ST_OUT;
            end
            mh2_pkg::ST_OUT: begin
                // last avalanche step goes straight into the result register
                if (out_free) begin
                    out_next       = h_reg ^ (h_reg >> mh2_pkg::FIN_SHIFT_B);
                    out_valid_next = 1'b1;
                    state_next     = mh2_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mh2_pkg::ST_IDLE;
            end
        endcase
    end

    // command capture on pop
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cmd_reg <= q_cmd;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        h_reg   <= h_next;
        k_reg   <= k_next;
        out_reg <= out_next;
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= mh2_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_hash_value = out_reg;

endmodule

// ===== rtl/murmurhash2_byte_stream.sv =====
// top level of the byte-stream murmurhash2 hasher
//
// Input channel s_*: one key byte per request with the key length and a
// last-byte flag; the length is sampled on a key's first byte and seeds the
// hash. A first byte with length zero returns the empty-key hash (zero).
// Output channel m_*: one 32-bit hash per key, issued after its last byte.
// The front packs bytes at one per cycle while the queue has room and hands
// one command per key start, full word or key end to a command queue of
// QUEUE_DEPTH entries. The back runs each command on one shared 32x32
// multiplier and keeps up with one byte per cycle on long keys while the
// receiver takes the hashes. With the back idle, m_valid rises once a key's
// last command has passed pop, any tail or word mix, avalanche and the
// result register.
// Reset (aresetn low, synchronous) empties the queue, drops a key in
// progress and clears m_valid. When the receiver stalls, the finished hash
// waits in the result register while the back starts the next key; once the
// queue fills, s_ready drops.
module murmurhash2_byte_stream #(
    parameter logic [31:0] MAX_KEY_BYTES = 32'd65535,
    parameter int          QUEUE_DEPTH   = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic [15:0] s_key_length,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_hash_value
);

    logic                     q_full, q_empty, q_push, q_pop;
    mh2_pkg::cmd_t            push_cmd, pop_cmd;
    logic [mh2_pkg::CMD_W-1:0] pop_bits;

    // byte packing and command issue
    mh2_front #(
        .MAX_KEY_BYTES(MAX_KEY_BYTES)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_key_length(s_key_length),
        .s_last_byte (s_last_byte),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (push_cmd)
    );

    // command queue
    mh2_fifo #(
        .WIDTH(mh2_pkg::CMD_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk   (aclk),
        .aresetn(aresetn),
        .push   (q_push),
        .wr_data(push_cmd),
        .full   (q_full),
        .pop    (q_pop),
        .rd_data(pop_bits),
        .empty  (q_empty)
    );

    assign pop_cmd = mh2_pkg::cmd_t'(pop_bits);

    // hash arithmetic and result register
    mh2_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_empty     (q_empty),
        .q_cmd       (pop_cmd),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_hash_value(m_hash_value)
    );

endmodule

// ===== rtl/mh2_checker.sv =====
// port-level checks of the murmurhash2 block, bound to the top level
module mh2_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_hash_value
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its value
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_hash_value))
        else $error("result changed while stalled");

    // reset clears the result valid flag
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // queue is empty after reset, so the input is ready
    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("input not ready right after reset");

endmodule

bind murmurhash2_byte_stream mh2_checker u_mh2_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_hash_value(m_hash_value)
);

// ===== dv/mh2_hash_checker.sv =====
// checker for the byte-stream murmurhash2 block: predicts each key hash and compares results
module mh2_hash_checker #(
    parameter logic [31:0] MAX_KEY_BYTES = 32'd65535
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic [15:0] s_key_length,
    input  logic        s_last_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_hash_value,
    output int          errors,
    output int          pending,
    output int          hashes_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    // predictor state of the hasher
    logic [31:0] run_hash;
    logic [23:0] part_word;
    logic [1:0]  phase;
    logic        in_key;

    // hashes predicted but not yet returned, oldest first
    logic [31:0] pending_hashes[$];

    // final avalanche of murmurhash2
    function automatic logic [31:0] avalanche(input logic [31:0] h);
        logic [31:0] x;
        x = h ^ (h >> mh2_pkg::FIN_SHIFT_A);
        x = x * mh2_pkg::MIX_MUL;
        x = x ^ (x >> mh2_pkg::FIN_SHIFT_B);
        return x;
    endfunction

    // fold one accepted byte into the running hash; report a finished hash if any
    task automatic absorb_byte(input logic [7:0] b, input logic [15:0] len, input logic lst,
                               output bit produced, output logic [31:0] hash);
        logic [31:0] k;
        logic [31:0] seed;
        produced = 1'b0;
        hash = '0;
        // first byte of a key seeds the hash with the saturated length
        if (!in_key) begin
            seed = (32'(len) > MAX_KEY_BYTES) ? MAX_KEY_BYTES : 32'(len);
            if (seed == 32'd0) begin
                produced = 1'b1;
                hash = avalanche(32'd0);
                return;
            end
            run_hash = seed;
            part_word = '0;
            phase = 2'd0;
            in_key = 1'b1;
        end
        // gather little-endian, mix on every fourth byte
        if (phase == 2'd3) begin
            k = {b, part_word};
            k = k * mh2_pkg::MIX_MUL;
            k = k ^ (k >> mh2_pkg::MIX_SHIFT);
            k = k * mh2_pkg::MIX_MUL;
            run_hash = (run_hash * mh2_pkg::MIX_MUL) ^ k;
            part_word = '0;
            phase = 2'd0;
        end else begin
            part_word[8*phase +: 8] = b;
            phase = phase + 2'd1;
        end
        if (!lst) return;
        // leftover tail, then avalanche
        if (phase != 2'd0) begin
            run_hash = run_hash ^ {8'h00, part_word};
            run_hash = run_hash * mh2_pkg::MIX_MUL;
        end
        produced = 1'b1;
        hash = avalanche(run_hash);
        run_hash = '0;
        part_word = '0;
        phase = 2'd0;
        in_key = 1'b0;
    endtask

    // watch both channels at the rising edge
    always @(posedge aclk) begin
        bit          produced;
        logic [31:0] hash;
        logic [31:0] want;
        if (!aresetn) begin
            run_hash = '0;
            part_word = '0;
            phase = 2'd0;
            in_key = 1'b0;
            pending_hashes.delete();
            errors = 0;
            hashes_checked = 0;
        end else begin
            // returned hash against the oldest prediction
            if (m_valid && m_ready) begin
                if (pending_hashes.size() == 0) begin
                    errors++;
                    $display("%0t: hash %h returned, expected none", $time, m_hash_value);
                end else begin
                    want = pending_hashes.pop_front();
                    if (m_hash_value !== want) begin
                        errors++;
                        $display("%0t: hash_value expected %h, got %h",
                                 $time, want, m_hash_value);
                    end
                end
                hashes_checked++;
            end
            // accepted request feeds the predictor
            if (s_valid && s_ready) begin
                absorb_byte(s_data_byte, s_key_length, s_last_byte, produced, hash);
                if (produced) pending_hashes.push_back(hash);
            end
        end
        pending = pending_hashes.size();
    end

endmodule

// ===== dv/tb.sv =====
// testbench top for the byte-stream murmurhash2 block: stimulus, back-pressure and verdict
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_REQUESTS = 850;

    typedef enum int {FILL_RAND, FILL_ZERO, FILL_ONES} fill_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic [15:0] s_key_length;
    logic        s_last_byte;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_hash_value;

    int errors;
    int pending;
    int hashes_checked;
    int requests_sent;
    int keys_sent;
    int empty_keys;
    int cycle_count;
    bit rush;

    murmurhash2_byte_stream dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_key_length (s_key_length),
        .s_last_byte  (s_last_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hash_value (m_hash_value)
    );

    mh2_hash_checker hash_chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_key_length   (s_key_length),
        .s_last_byte    (s_last_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hash_value   (m_hash_value),
        .errors         (errors),
        .pending        (pending),
        .hashes_checked (hashes_checked)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run limit
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d hashes outstanding", cycle_count, pending);
            $display("** murmurhash2_byte_stream: FAILED **");
            $finish;
        end
    end

    // one byte request, with a random gap ahead of it unless rush is set
    task automatic send_byte(input logic [7:0] b, input logic [15:0] len, input logic lst);
        int gap;
        gap = rush ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data_byte = b;
        s_key_length = len;
        s_last_byte = lst;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        requests_sent++;
    endtask

    // a whole key; scramble puts random lengths on the bytes after the first
    task automatic send_key(input int n, input logic [15:0] len, input fill_t fill,
                            input bit scramble);
        logic [7:0]  b;
        logic [15:0] l;
        for (int i = 0; i < n; i++) begin
            case (fill)
                FILL_ZERO: b = 8'h00;
                FILL_ONES: b = 8'hff;
                default:   b = 8'($urandom_range(0, 255));
            endcase
            l = (i > 0 && scramble) ? 16'($urandom_range(0, 65535)) : len;
            send_byte(b, l, i == n - 1);
        end
        keys_sent++;
    endtask

    // empty key: length zero on a first byte
    task automatic send_empty(input logic [7:0] b, input logic lst);
        send_byte(b, 16'd0, lst);
        empty_keys++;
    endtask

    // hold off the sender until every predicted hash has come back
    task automatic drain();
        s_valid = 1'b0;
        while (pending != 0) @(negedge aclk);
    endtask

    // receiver with random stalls unless rush is set
    initial begin
        int stall;
        m_ready = 1'b0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            stall = rush ? 0 : $urandom_range(0, 12);
            if (stall > 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    // stimulus and verdict
    initial begin
        int pick;
        int n;
        rush = 1'b0;
        requests_sent = 0;
        keys_sent = 0;
        empty_keys = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data_byte = '0;
        s_key_length = '0;
        s_last_byte = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: empty keys, every tail size, full word, extremes, length mismatch
        send_empty(8'hff, 1'b1);
        send_empty(8'h00, 1'b0);
        send_key(1, 16'd1, FILL_ONES, 1'b0);
        send_key(2, 16'd2, FILL_ZERO, 1'b0);
        send_key(3, 16'd3, FILL_ONES, 1'b0);
        send_key(4, 16'd4, FILL_ONES, 1'b0);
        send_key(5, 16'd5, FILL_RAND, 1'b0);
        send_key(2, 16'hffff, FILL_ONES, 1'b0);
        send_key(4, 16'd3, FILL_RAND, 1'b1);
        send_key(1, 16'h8000, FILL_ZERO, 1'b0);
        drain();

        // random keys, mostly well formed
        while (requests_sent < RANDOM_REQUESTS) begin
            if ($urandom_range(0, 7) == 0) rush = !rush;
            pick = $urandom_range(0, 99);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
            if (pick < 75) begin
                send_key(n, 16'(n), FILL_RAND, 1'b0);
            end else if (pick < 85) begin
                send_key(n, 16'($urandom_range(1, 65535)), FILL_RAND, 1'($urandom_range(0, 1)));
            end else if (pick < 92) begin
                send_empty(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end else begin
                send_key(n, 16'(n), pick[0] ? FILL_ONES : FILL_ZERO, 1'b0);
            end
            if ($urandom_range(0, 199) == 0) drain();
        end

        // wait out the last hashes and the pipeline
        rush = 1'b0;
        drain();
        repeat (20) @(negedge aclk);

        $display("%0d byte requests in %0d keys plus %0d empty keys, %0d hashes compared",
                 requests_sent, keys_sent, empty_keys, hashes_checked);
        if (errors == 0 && pending == 0) begin
            $display("** murmurhash2_byte_stream: PASSED **");
        end else begin
            $display("%0d mismatches, %0d hashes missing", errors, pending);
            $display("** murmurhash2_byte_stream: FAILED **");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/mh2_pkg.sv
rtl/mh2_front.sv
rtl/mh2_fifo.sv
rtl/mh2_back.sv
rtl/murmurhash2_byte_stream.sv
rtl/mh2_checker.sv
dv/mh2_hash_checker.sv
dv/tb.sv
